// ----- design/slx_pkg.sv -----
// slx_pkg: beat types, token kinds and number-grammar helpers for the s-expression lexer
// depends on nothing; imported by slx_core, s_expression_lexer_top and the testbench
package slx_pkg;

   typedef enum logic [3:0] {
      K_LPAREN   = 4'd0,
      K_RPAREN   = 4'd1,
      K_SYMBOL   = 4'd2,
      K_INTEGER  = 4'd3,
      K_REAL     = 4'd4,
      K_STRING   = 4'd5,
      K_CONSTANT = 4'd6,
      K_QUOTE    = 4'd7,
      K_COMMENT  = 4'd8,
      K_UNKNOWN  = 4'd9,
      K_BADTOK   = 4'd10,
      K_BADESC   = 4'd11
   } kind_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic [9:0]         start_col;
      logic [9:0]         length;
      logic signed [63:0] int_value;
      logic               last_of_run;
   } rsp_type;

   // what one character step produces
   typedef struct packed {
      logic [1:0] count;
      rsp_type    r0;
      rsp_type    r1;
   } emit_type;

   localparam logic [9:0]  LEN_MAX = 10'd1023;
   localparam logic [63:0] INT_LIM = 64'h8000_0000_0000_0000;

   localparam logic [4:0] NS_START   = 5'd0;
   localparam logic [4:0] NS_SIGN    = 5'd1;
   localparam logic [4:0] NS_ZERO    = 5'd2;
   localparam logic [4:0] NS_INT     = 5'd3;
   localparam logic [4:0] NS_DOT0    = 5'd4;
   localparam logic [4:0] NS_FRAC    = 5'd5;
   localparam logic [4:0] NS_E       = 5'd6;
   localparam logic [4:0] NS_ES      = 5'd7;
   localparam logic [4:0] NS_EXP     = 5'd8;
   localparam logic [4:0] NS_HEX0    = 5'd9;
   localparam logic [4:0] NS_HEXINT  = 5'd10;
   localparam logic [4:0] NS_HEXDOT0 = 5'd11;
   localparam logic [4:0] NS_HEXFRAC = 5'd12;
   localparam logic [4:0] NS_HEXP    = 5'd13;
   localparam logic [4:0] NS_HEXPS   = 5'd14;
   localparam logic [4:0] NS_HEXEXP  = 5'd15;
   localparam logic [4:0] NS_INF1    = 5'd16;
   localparam logic [4:0] NS_INF2    = 5'd17;
   localparam logic [4:0] NS_INF3    = 5'd18;
   localparam logic [4:0] NS_INF4    = 5'd19;
   localparam logic [4:0] NS_INF5    = 5'd20;
   localparam logic [4:0] NS_INF6    = 5'd21;
   localparam logic [4:0] NS_INF7    = 5'd22;
   localparam logic [4:0] NS_INF8    = 5'd23;
   localparam logic [4:0] NS_NAN1    = 5'd24;
   localparam logic [4:0] NS_NAN2    = 5'd25;
   localparam logic [4:0] NS_NAN3    = 5'd26;
   localparam logic [4:0] NS_DEAD    = 5'd27;

   typedef struct packed {
      logic [4:0]  ns;
      logic [63:0] acc;
      logic        neg;
      logic        ovf;
   } num_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      return is_digit(c) || (l >= "a" && l <= "f");
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return c == "+" || c == "-";
   endfunction

   function automatic logic in_symbol(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "@" || c == "#" || c == "$" ||
             c == "&" || c == ":" || c == "|" || c == "?" || c == "." || c == "_" ||
             c == "-" || c == "+" || c == "*" || c == "!";
   endfunction

   function automatic logic [4:0] num_next(input logic [4:0] s, input logic [7:0] c);
      logic [7:0] l;
      logic [4:0] r;
      l = c | 8'h20;
      r = NS_DEAD;
      unique case (s)
         NS_START, NS_SIGN: begin
            if (s == NS_START && is_sign(c)) r = NS_SIGN;
            else if (c == "0") r = NS_ZERO;
            else if (is_digit(c)) r = NS_INT;
            else if (c == ".") r = NS_DOT0;
            else if (l == "i") r = NS_INF1;
            else if (l == "n") r = NS_NAN1;
         end
         NS_ZERO, NS_INT: begin
            if (s == NS_ZERO && l == "x") r = NS_HEX0;
            else if (is_digit(c)) r = NS_INT;
            else if (c == ".") r = NS_FRAC;
            else if (l == "e") r = NS_E;
         end
         NS_DOT0: r = is_digit(c) ? NS_FRAC : NS_DEAD;
         NS_FRAC: begin
            if (is_digit(c)) r = NS_FRAC;
            else if (l == "e") r = NS_E;
         end
         NS_E, NS_ES, NS_EXP: begin
            if (s == NS_E && is_sign(c)) r = NS_ES;
            else if (is_digit(c)) r = NS_EXP;
         end
         NS_HEX0: begin
            if (is_hex(c)) r = NS_HEXINT;
            else if (c == ".") r = NS_HEXDOT0;
         end
         NS_HEXINT: begin
            if (is_hex(c)) r = NS_HEXINT;
            else if (c == ".") r = NS_HEXFRAC;
            else if (l == "p") r = NS_HEXP;
         end
         NS_HEXDOT0: r = is_hex(c) ? NS_HEXFRAC : NS_DEAD;
         NS_HEXFRAC: begin
            if (is_hex(c)) r = NS_HEXFRAC;
            else if (l == "p") r = NS_HEXP;
         end
         NS_HEXP, NS_HEXPS, NS_HEXEXP: begin
            if (s == NS_HEXP && is_sign(c)) r = NS_HEXPS;
            else if (is_digit(c)) r = NS_HEXEXP;
         end
         NS_INF1: r = (l == "n") ? NS_INF2 : NS_DEAD;
         NS_INF2: r = (l == "f") ? NS_INF3 : NS_DEAD;
         NS_INF3: r = (l == "i") ? NS_INF4 : NS_DEAD;
         NS_INF4: r = (l == "n") ? NS_INF5 : NS_DEAD;
         NS_INF5: r = (l == "i") ? NS_INF6 : NS_DEAD;
         NS_INF6: r = (l == "t") ? NS_INF7 : NS_DEAD;
         NS_INF7: r = (l == "y") ? NS_INF8 : NS_DEAD;
         NS_NAN1: r = (l == "a") ? NS_NAN2 : NS_DEAD;
         NS_NAN2: r = (l == "n") ? NS_NAN3 : NS_DEAD;
         default: r = NS_DEAD;
      endcase
      return r;
   endfunction

   // one character into the number recognizer, decimal value saturates at 2^63
   function automatic num_type num_feed(input num_type cur, input logic [7:0] c);
      num_type    nx;
      logic [67:0] p;
      nx = cur;
      if (cur.ns == NS_START && c == "-") nx.neg = 1'b1;
      nx.ns = num_next(cur.ns, c);
      p = ({4'd0, cur.acc} << 3) + ({4'd0, cur.acc} << 1) + 68'(c - "0");
      if ((nx.ns == NS_ZERO || nx.ns == NS_INT) && is_digit(c)) begin
         if (cur.ovf || p > {4'd0, INT_LIM}) begin
            nx.ovf = 1'b1;
            nx.acc = INT_LIM;
         end else begin
            nx.acc = p[63:0];
         end
      end
      return nx;
   endfunction

endpackage

// ----- design/slx_core.sv -----
// slx_core: lexer state and the one-character step that yields up to two tokens
// depends on slx_pkg
module slx_core import slx_pkg::*; #(
   parameter int LINE_LENGTH = 1024
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  req_type  item,
   output emit_type emit
);

   localparam int COL_W = $clog2(LINE_LENGTH);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_LENGTH - 1);

   typedef enum logic [2:0] {
      M_IDLE, M_LTGT, M_CONST, M_SYM, M_STR, M_STRESC, M_SKIP
   } mode_type;

   mode_type         mode_ff, mode_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] tstart_ff, tstart_in;
   logic [9:0]       tlen_ff, tlen_in;
   num_type          num_ff, num_in;

   function automatic rsp_type mk(input kind_type k, input logic [9:0] s,
                                  input logic [9:0] len, input logic [63:0] v);
      rsp_type r;
      r.kind        = k;
      r.start_col   = s;
      r.length      = len;
      r.int_value   = v;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   logic [7:0]   c;
   logic         eol;
   logic         flush_v, idle_v, run_idle;
   rsp_type      flush_r, idle_r, sym_r;
   logic [9:0]   col10, tstart10, tlen_inc;
   logic [COL_W:0] diff;
   logic [9:0]   diff_sat;
   logic [63:0]  int_v;
   num_type      num_fresh;

   always_comb begin
      c         = item.ch;
      eol       = item.end_of_line || item.ch == 8'd0;
      col10     = 10'(col_ff);
      tstart10  = 10'(tstart_ff);
      tlen_inc  = (tlen_ff != LEN_MAX) ? tlen_ff + 10'd1 : LEN_MAX;
      diff      = {1'b0, col_ff} - {1'b0, tstart_ff} + {{COL_W{1'b0}}, !eol};
      diff_sat  = (32'(diff) > 32'(LEN_MAX)) ? LEN_MAX : 10'(diff);
      num_fresh = '{ns: NS_START, acc: 64'd0, neg: 1'b0, ovf: 1'b0};

      // value and class of a finished symbol run
      if (num_ff.neg) begin
         int_v = (num_ff.ovf || num_ff.acc > INT_LIM) ? INT_LIM : 64'd0 - num_ff.acc;
      end else begin
         int_v = (num_ff.ovf || num_ff.acc >= INT_LIM) ? INT_LIM - 64'd1 : num_ff.acc;
      end
      if (num_ff.ns == NS_ZERO || num_ff.ns == NS_INT) begin
         sym_r = mk(K_INTEGER, tstart10, tlen_ff, int_v);
      end else if (num_ff.ns == NS_FRAC || num_ff.ns == NS_EXP || num_ff.ns == NS_HEXINT ||
                   num_ff.ns == NS_HEXFRAC || num_ff.ns == NS_HEXEXP ||
                   num_ff.ns == NS_INF3 || num_ff.ns == NS_INF8 || num_ff.ns == NS_NAN3) begin
         sym_r = mk(K_REAL, tstart10, tlen_ff, 64'd0);
      end else begin
         sym_r = mk(K_SYMBOL, tstart10, tlen_ff, 64'd0);
      end

      mode_in   = mode_ff;
      tstart_in = tstart_ff;
      tlen_in   = tlen_ff;
      num_in    = num_ff;
      col_in    = (col_ff != COL_LAST) ? col_ff + 1'b1 : col_ff;
      flush_v   = 1'b0;
      flush_r   = mk(K_SYMBOL, tstart10, 10'd1, 64'd0);
      run_idle  = 1'b0;
      idle_v    = 1'b0;
      idle_r    = mk(K_UNKNOWN, col10, 10'd1, 64'd0);

      if (eol) begin
         col_in  = '0;
         mode_in = M_IDLE;
         unique case (mode_ff)
            M_LTGT:   flush_v = 1'b1;
            M_CONST: begin
               flush_v = 1'b1;
               flush_r = mk(K_CONSTANT, tstart10, tlen_ff, 64'd0);
            end
            M_SYM: begin
               flush_v = 1'b1;
               flush_r = sym_r;
            end
            M_STR: begin
               flush_v = 1'b1;
               flush_r = mk(K_STRING, tstart10, tlen_ff, 64'd0);
            end
            M_STRESC: begin
               flush_v = 1'b1;
               flush_r = mk(K_BADESC, tstart10, diff_sat, 64'd0);
            end
            M_IDLE, M_SKIP: flush_v = 1'b0;
            default:        flush_v = 1'b0;
         endcase
      end else begin
         unique case (mode_ff)
            M_LTGT: begin
               flush_v = 1'b1;
               if (c == "=") begin
                  flush_r = mk(K_SYMBOL, tstart10, 10'd2, 64'd0);
                  mode_in = M_IDLE;
               end else begin
                  run_idle = 1'b1;
               end
            end
            M_CONST: begin
               if (is_alpha(c)) begin
                  tlen_in = tlen_inc;
               end else begin
                  flush_v  = 1'b1;
                  flush_r  = mk(K_CONSTANT, tstart10, tlen_ff, 64'd0);
                  run_idle = 1'b1;
               end
            end
            M_SYM: begin
               if (in_symbol(c)) begin
                  tlen_in = tlen_inc;
                  num_in  = num_feed(num_ff, c);
               end else begin
                  flush_v  = 1'b1;
                  flush_r  = sym_r;
                  run_idle = 1'b1;
               end
            end
            M_STR: begin
               if (c == "\"") begin
                  flush_v = 1'b1;
                  flush_r = mk(K_STRING, tstart10, tlen_ff, 64'd0);
                  mode_in = M_IDLE;
               end else if (c == "\\") begin
                  mode_in = M_STRESC;
               end else begin
                  tlen_in = tlen_inc;
               end
            end
            M_STRESC: begin
               if (c == "\\" || c == "\"") begin
                  tlen_in = tlen_inc;
                  mode_in = M_STR;
               end else begin
                  flush_v = 1'b1;
                  flush_r = mk(K_BADESC, tstart10, diff_sat, 64'd0);
                  mode_in = M_SKIP;
               end
            end
            M_SKIP:  mode_in = M_SKIP;
            M_IDLE:  run_idle = 1'b1;
            default: run_idle = 1'b1;
         endcase

         // a character lexed from between tokens
         if (run_idle) begin
            mode_in = M_IDLE;
            idle_v  = 1'b1;
            if (c == " " || c == 8'd10) begin
               idle_v = 1'b0;
            end else if (c == "(") begin
               idle_r.kind = K_LPAREN;
            end else if (c == "+" || c == "*" || c == "/" || c == "%" || c == "=" ||
                         c == "^") begin
               idle_r.kind = K_SYMBOL;
            end else if (c == "\\") begin
               idle_r.kind = K_BADTOK;
            end else begin
               tstart_in = col_ff;
               if (c == "\"") begin
                  idle_v  = 1'b0;
                  mode_in = M_STR;
                  tlen_in = 10'd0;
               end else if (c == "<" || c == ">") begin
                  idle_v  = 1'b0;
                  mode_in = M_LTGT;
               end else if (c == "'") begin
                  idle_r.kind = K_QUOTE;
               end else if (c == ";") begin
                  mode_in     = M_SKIP;
                  idle_r.kind = K_COMMENT;
               end else if (c == ")") begin
                  idle_r.kind = K_RPAREN;
               end else if (c == "#") begin
                  idle_v  = 1'b0;
                  mode_in = M_CONST;
                  tlen_in = 10'd1;
               end else if (in_symbol(c)) begin
                  idle_v  = 1'b0;
                  mode_in = M_SYM;
                  tlen_in = 10'd1;
                  num_in  = num_feed(num_fresh, c);
               end
            end
         end
      end

      // pack in order: pending token first, then the new one
      emit.count = 2'(flush_v) + 2'(idle_v);
      emit.r0    = flush_v ? flush_r : idle_r;
      emit.r1    = idle_r;
      emit.r0.last_of_run = !(flush_v && idle_v);
      emit.r1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         col_ff    <= '0;
         tstart_ff <= '0;
         tlen_ff   <= '0;
         num_ff    <= '{ns: NS_START, acc: 64'd0, neg: 1'b0, ovf: 1'b0};
      end else if (step) begin
         mode_ff   <= mode_in;
         col_ff    <= col_in;
         tstart_ff <= tstart_in;
         tlen_ff   <= tlen_in;
         num_ff    <= num_in;
      end
   end

endmodule

// ----- design/s_expression_lexer_top.sv -----
// s_expression_lexer_top: character beats in, token beats out, with a small result queue
// depends on slx_pkg and slx_core
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid/req_ready  | req_type: ch, end_of_line
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_type: kind, start_col, length,
//           |           |                      |   int_value, last_of_run
//
// one character beat per clock while the lexer step runs; each beat is held in the input register and
//   is lexed there in a single pass, pushing zero, one or two tokens into a 4-deep queue
// the lexer step runs when the queue holds at most two tokens, so the output side is
//   what limits the rate: one token per clock leaves on rsp while rsp_ready is high
// a token reaches rsp through the input register and then the result queue
// reset (synchronous) clears lexer state, column and queue; no clearing pass
// a stalled rsp fills the queue and then holds req_ready low
module s_expression_lexer_top import slx_pkg::*; #(
   parameter int LINE_LENGTH = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // input register
   logic     in_v_ff;
   req_type  in_ff;

   // result queue
   rsp_type    mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff, cnt_in;

   emit_type emit;
   logic     proc, pop;

   assign proc      = in_v_ff && (cnt_ff <= 3'd2);
   assign req_ready = !in_v_ff || proc;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = cnt_ff != 3'd0;
   assign rsp_data  = mem_ff[rp_ff];
   assign cnt_in    = cnt_ff + (proc ? 3'(emit.count) : 3'd0) - 3'(pop);

   slx_core #(.LINE_LENGTH(LINE_LENGTH)) u_core (
      .clock (clock),
      .reset (reset),
      .step  (proc),
      .item  (in_ff),
      .emit  (emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_v_ff <= 1'b1;
      end else if (proc) begin
         in_v_ff <= 1'b0;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (proc && emit.count != 2'd0) begin
         mem_ff[wp_ff] <= emit.r0;
      end
      if (proc && emit.count == 2'd2) begin
         mem_ff[wp_ff + 2'd1] <= emit.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (proc) begin
            wp_ff <= wp_ff + emit.count;
         end
         if (pop) begin
            rp_ff <= rp_ff + 2'd1;
         end
         cnt_ff <= cnt_in;
      end
   end

   // queue never holds more than four tokens
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 3'd4)
      else $error("result queue overfilled");

   // queue is empty right after reset
   a_cnt_reset: assert property (@(posedge clock) $past(reset) |-> cnt_ff == 3'd0)
      else $error("queue not empty after reset");

   // a second token in one step always comes with a first one
   a_two_tokens: assert property (@(posedge clock) disable iff (reset)
      proc && emit.count == 2'd2 |-> emit.r0.last_of_run == 1'b0)
      else $error("two tokens without a leading one");

   // queue depth stays put when there is neither a lexer step nor a pop
   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      !proc && !pop |=> cnt_ff == $past(cnt_ff))
      else $error("queue count drifted");

endmodule

// ----- dv/tb_s_expression_lexer_top.sv -----
// tb_s_expression_lexer_top: self-checking bench for the s-expression lexer, with a token predictor
// depends on slx_pkg and s_expression_lexer_top
module tb_s_expression_lexer_top;
   import slx_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // lexer modes of the predictor
   typedef enum logic [2:0] {
      LM_IDLE, LM_LTGT, LM_CONST, LM_SYM, LM_STR, LM_STRESC, LM_SKIP
   } lex_mode_type;

   localparam int LINE_LEN   = 1024;
   localparam int CYCLE_STOP = 400000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   s_expression_lexer_top #(.LINE_LENGTH(LINE_LEN)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // character beats waiting to be driven, tokens waiting to come out
   req_type char_queue[$];
   rsp_type token_queue[$];
   int      error_count = 0;
   int      cycle_count = 0;
   logic    all_sent = 1'b0;

   // predictor state
   lex_mode_type p_mode;
   int unsigned  p_col, p_start, p_len;
   logic [4:0]   p_ns;
   logic [63:0]  p_acc;
   logic         p_neg, p_ovf;
   rsp_type      step_out[$];

   function automatic logic c_digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic c_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic c_hex(logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      return c_digit(c) || (l >= "a" && l <= "f");
   endfunction

   function automatic logic c_sign(logic [7:0] c);
      return c == "+" || c == "-";
   endfunction

   function automatic logic c_symchar(logic [7:0] c);
      return c_alpha(c) || c_digit(c) || c == "@" || c == "#" || c == "$" || c == "&" ||
             c == ":" || c == "|" || c == "?" || c == "." || c == "_" || c == "-" ||
             c == "+" || c == "*" || c == "!";
   endfunction

   // number grammar: one step of the strtol/strtod recognizer
   function automatic logic [4:0] grammar_step(logic [4:0] s, logic [7:0] c);
      logic [7:0] l;
      string      inf_word;
      l = c | 8'h20;
      inf_word = "infinity";
      if (s >= NS_INF1 && s <= NS_INF8) begin
         if (s < NS_INF8 && l == inf_word[s - NS_INF1 + 1]) return s + 5'd1;
         return NS_DEAD;
      end
      if (s == NS_NAN1) return l == "a" ? NS_NAN2 : NS_DEAD;
      if (s == NS_NAN2) return l == "n" ? NS_NAN3 : NS_DEAD;
      case (s)
         NS_START, NS_SIGN: begin
            if (s == NS_START && c_sign(c)) return NS_SIGN;
            if (c == "0") return NS_ZERO;
            if (c_digit(c)) return NS_INT;
            if (c == ".") return NS_DOT0;
            if (l == "i") return NS_INF1;
            if (l == "n") return NS_NAN1;
            return NS_DEAD;
         end
         NS_ZERO, NS_INT: begin
            if (s == NS_ZERO && l == "x") return NS_HEX0;
            if (c_digit(c)) return NS_INT;
            if (c == ".") return NS_FRAC;
            return l == "e" ? NS_E : NS_DEAD;
         end
         NS_DOT0: return c_digit(c) ? NS_FRAC : NS_DEAD;
         NS_FRAC: begin
            if (c_digit(c)) return NS_FRAC;
            return l == "e" ? NS_E : NS_DEAD;
         end
         NS_E, NS_ES, NS_EXP: begin
            if (s == NS_E && c_sign(c)) return NS_ES;
            return c_digit(c) ? NS_EXP : NS_DEAD;
         end
         NS_HEX0: begin
            if (c_hex(c)) return NS_HEXINT;
            return c == "." ? NS_HEXDOT0 : NS_DEAD;
         end
         NS_HEXINT: begin
            if (c_hex(c)) return NS_HEXINT;
            if (c == ".") return NS_HEXFRAC;
            return l == "p" ? NS_HEXP : NS_DEAD;
         end
         NS_HEXDOT0: return c_hex(c) ? NS_HEXFRAC : NS_DEAD;
         NS_HEXFRAC: begin
            if (c_hex(c)) return NS_HEXFRAC;
            return l == "p" ? NS_HEXP : NS_DEAD;
         end
         NS_HEXP, NS_HEXPS, NS_HEXEXP: begin
            if (s == NS_HEXP && c_sign(c)) return NS_HEXPS;
            return c_digit(c) ? NS_HEXEXP : NS_DEAD;
         end
         default: return NS_DEAD;
      endcase
   endfunction

   task automatic push_token(kind_type k, int unsigned st, int unsigned len,
                             logic [63:0] v);
      rsp_type t;
      t.kind = k;
      t.start_col = st[9:0];
      t.length = len > 1023 ? 10'd1023 : len[9:0];
      t.int_value = v;
      t.last_of_run = 1'b0;
      step_out.push_back(t);
   endtask

   function automatic int unsigned len_inc(int unsigned v);
      return v < 1023 ? v + 1 : 1023;
   endfunction

   task automatic number_feed(logic [7:0] c);
      logic [63:0] d;
      if (p_ns == NS_START && c == "-") p_neg = 1'b1;
      p_ns = grammar_step(p_ns, c);
      if ((p_ns == NS_ZERO || p_ns == NS_INT) && c_digit(c)) begin
         d = 64'(c - 8'h30);
         if (p_ovf || p_acc > ((64'h8000_0000_0000_0000 - d) / 10)) begin
            p_ovf = 1'b1;
            p_acc = 64'h8000_0000_0000_0000;
         end else begin
            p_acc = p_acc * 10 + d;
         end
      end
   endtask

   task automatic close_symbol();
      logic [63:0] lim;
      logic [63:0] v;
      lim = 64'h8000_0000_0000_0000;
      if (p_ns == NS_ZERO || p_ns == NS_INT) begin
         if (p_neg) v = (p_ovf || p_acc > lim) ? lim : 64'd0 - p_acc;
         else v = (p_ovf || p_acc >= lim) ? lim - 1 : p_acc;
         push_token(K_INTEGER, p_start, p_len, v);
      end else if (p_ns == NS_FRAC || p_ns == NS_EXP || p_ns == NS_HEXINT ||
                   p_ns == NS_HEXFRAC || p_ns == NS_HEXEXP || p_ns == NS_INF3 ||
                   p_ns == NS_INF8 || p_ns == NS_NAN3) begin
         push_token(K_REAL, p_start, p_len, 0);
      end else begin
         push_token(K_SYMBOL, p_start, p_len, 0);
      end
   endtask

   // a character seen between tokens
   task automatic idle_char(logic [7:0] c, int unsigned col);
      p_mode = LM_IDLE;
      if (c == " " || c == 8'h0a) return;
      if (c == "(") begin push_token(K_LPAREN, col, 1, 0); return; end
      if (c == "+" || c == "*" || c == "/" || c == "%" || c == "=" || c == "^") begin
         push_token(K_SYMBOL, col, 1, 0);
         return;
      end
      if (c == "\\") begin push_token(K_BADTOK, col, 1, 0); return; end
      p_start = col;
      if (c == "\"") begin p_mode = LM_STR; p_len = 0; return; end
      if (c == "<" || c == ">") begin p_mode = LM_LTGT; return; end
      if (c == "'") begin push_token(K_QUOTE, col, 1, 0); return; end
      if (c == ";") begin
         p_mode = LM_SKIP;
         push_token(K_COMMENT, col, 1, 0);
         return;
      end
      if (c == ")") begin push_token(K_RPAREN, col, 1, 0); return; end
      if (c == "#") begin p_mode = LM_CONST; p_len = 1; return; end
      if (c_symchar(c)) begin
         p_mode = LM_SYM;
         p_len = 1;
         p_ns = NS_START;
         p_acc = 0;
         p_neg = 1'b0;
         p_ovf = 1'b0;
         number_feed(c);
         return;
      end
      push_token(K_UNKNOWN, col, 1, 0);
   endtask

   // lex one accepted beat and queue the tokens it completes
   task automatic lex_beat(req_type b);
      int unsigned col;
      col = p_col;
      step_out.delete();
      if (b.end_of_line || b.ch == 8'h00) begin
         case (p_mode)
            LM_LTGT:   push_token(K_SYMBOL, p_start, 1, 0);
            LM_CONST:  push_token(K_CONSTANT, p_start, p_len, 0);
            LM_SYM:    close_symbol();
            LM_STR:    push_token(K_STRING, p_start, p_len, 0);
            LM_STRESC: push_token(K_BADESC, p_start, col - p_start, 0);
            default: ;
         endcase
         p_mode = LM_IDLE;
         p_col = 0;
      end else begin
         case (p_mode)
            LM_LTGT: begin
               if (b.ch == "=") begin
                  push_token(K_SYMBOL, p_start, 2, 0);
                  p_mode = LM_IDLE;
               end else begin
                  push_token(K_SYMBOL, p_start, 1, 0);
                  idle_char(b.ch, col);
               end
            end
            LM_CONST: begin
               if (c_alpha(b.ch)) p_len = len_inc(p_len);
               else begin
                  push_token(K_CONSTANT, p_start, p_len, 0);
                  idle_char(b.ch, col);
               end
            end
            LM_SYM: begin
               if (c_symchar(b.ch)) begin
                  p_len = len_inc(p_len);
                  number_feed(b.ch);
               end else begin
                  close_symbol();
                  idle_char(b.ch, col);
               end
            end
            LM_STR: begin
               if (b.ch == "\"") begin
                  push_token(K_STRING, p_start, p_len, 0);
                  p_mode = LM_IDLE;
               end else if (b.ch == "\\") p_mode = LM_STRESC;
               else p_len = len_inc(p_len);
            end
            LM_STRESC: begin
               if (b.ch == "\\" || b.ch == "\"") begin
                  p_len = len_inc(p_len);
                  p_mode = LM_STR;
               end else begin
                  push_token(K_BADESC, p_start, col - p_start + 1, 0);
                  p_mode = LM_SKIP;
               end
            end
            LM_SKIP: ;
            default: idle_char(b.ch, col);
         endcase
         if (p_col < LINE_LEN - 1) p_col = p_col + 1;
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
      foreach (step_out[i]) token_queue.push_back(step_out[i]);
   endtask

   // ---------------- stimulus generation ----------------
   task automatic add_char(logic [7:0] c);
      req_type b;
      b.ch = c;
      b.end_of_line = 1'b0;
      char_queue.push_back(b);
   endtask

   task automatic add_eol();
      req_type b;
      b.ch = 8'($urandom);   // ignored under end of line
      b.end_of_line = 1'b1;
      char_queue.push_back(b);
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endtask

   // a random lexeme, mostly well formed
   function automatic string rand_lexeme();
      string s;
      string alpha;
      int    n;
      alpha = "abcxyzIFNeEpP09_.+-#@!?";
      s = "";
      case ($urandom_range(0, 17))
         0: begin
            n = $urandom_range(1, 22);
            if ($urandom_range(0, 2) == 0) s = "-";
            else if ($urandom_range(0, 3) == 0) s = "+";
            for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(48, 57)))};
         end
         1: s = $sformatf("%0d.%0de%0d", $urandom_range(0, 99), $urandom_range(0, 99),
                          $urandom_range(0, 9));
         2: s = $sformatf("0x%0h.%0hp-%0d", $urandom_range(0, 999), $urandom_range(0, 99),
                          $urandom_range(0, 9));
         3: case ($urandom_range(0, 5))
               0: s = "inf";
               1: s = "-Infinity";
               2: s = "NaN";
               3: s = "infin";
               4: s = "+.5";
               default: s = "1e+";
            endcase
         4: begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) s = {s, string'(alpha[$urandom_range(0, 22)])};
         end
         5: begin
            if ($urandom_range(0, 1) != 0) s = "#t";
            else s = "#nil";
         end
         6: begin
            s = "\"";
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(0, 5))
                  0: s = {s, "\\\\"};
                  1: s = {s, "\\\""};
                  default: s = {s, string'(8'($urandom_range(32, 126)))};
               endcase
            end
            if ($urandom_range(0, 5) != 0) s = {s, "\""};
         end
         7: s = "(";
         8: s = ")";
         9: begin
            if ($urandom_range(0, 1) != 0) s = "<=";
            else s = ">";
         end
         10: s = "'";
         11: s = "\"ab\\q rest";
         12: s = "; note";
         13: s = string'(8'($urandom_range(1, 255)));
         default: s = string'(8'($urandom_range(32, 126)));
      endcase
      return s;
   endfunction

   task automatic build_stimulus();
      string line;
      // directed: delimiters, operators, comparisons, constants, quote, comment
      add_text("(+ < <= > >= #t 'x) ;z");
      add_eol();
      add_text("9223372036854775807 9223372036854775808 -9223372036854775808");
      add_text(" -9223372036854775809 0x1f 1.5e-3 .5 inf nan nan2 \\ \t");
      add_char(8'hff);
      add_char(8'h80);
      add_eol();
      add_text("\"a\\\\b\\\"c\" \"open");
      add_eol();
      add_text("\"bad\\");
      add_eol();
      add_text("\"x\\n skipped )");
      add_char(8'h00);
      add_text("#abc");
      add_eol();
      // random lines
      while (char_queue.size() < 480) begin
         line = "";
         repeat ($urandom_range(1, 8)) begin
            line = {line, rand_lexeme()};
            if ($urandom_range(0, 3) != 0) line = {line, " "};
         end
         if ($urandom_range(0, 40) == 0) line = {line, "\n"};
         add_text(line);
         if ($urandom_range(0, 19) == 0) add_char(8'h00);
         else add_eol();
      end
      // one very long line: column and length saturation
      for (int i = 0; i < 1100; i++) add_char(i < 1040 ? "7" : "a");
      add_text(" )");
      add_eol();
   endtask

   // ---------------- driver: bursts and gaps ----------------
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else if (!req_valid || req_ready) begin
         // the current beat (if any) is accepted at this edge
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (char_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= char_queue.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
            all_sent <= 1'b1;
         end
      end
   end

   // ---------------- receiver stall pattern ----------------
   int hold_count = 0;
   int stall_phase = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         stall_phase <= (stall_phase + 1) % 512;
         if (cycle_count == 300) hold_count <= 300;    // long hold-off to fill the queue
         else if (hold_count > 0) hold_count <= hold_count - 1;
         if (hold_count > 1 || cycle_count == 300) rsp_ready <= 1'b0;
         else if (stall_phase < 160) rsp_ready <= 1'b1;   // a stretch with no stalls
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (req_valid && req_ready) lex_beat(req_data);
         if (rsp_valid && rsp_ready) begin
            if (token_queue.size() == 0) begin
               $error("token beat with nothing expected: kind %0d", rsp_data.kind);
               error_count++;
            end else begin
               want = token_queue.pop_front();
               if (rsp_data.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_data.kind);
                  error_count++;
               end
               if (rsp_data.start_col !== want.start_col) begin
                  $error("start_col: expected %0d, got %0d", want.start_col,
                         rsp_data.start_col);
                  error_count++;
               end
               if (rsp_data.length !== want.length) begin
                  $error("length: expected %0d, got %0d", want.length, rsp_data.length);
                  error_count++;
               end
               if (rsp_data.int_value !== want.int_value) begin
                  $error("int_value: expected %0d, got %0d", want.int_value,
                         rsp_data.int_value);
                  error_count++;
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                         rsp_data.last_of_run);
                  error_count++;
               end
            end
         end
      end
   end

   // ---------------- run control ----------------
   initial begin
      reset = 1'b1;
      p_mode = LM_IDLE;
      p_col = 0;
      p_start = 0;
      p_len = 0;
      p_ns = NS_START;
      p_acc = 0;
      p_neg = 1'b0;
      p_ovf = 1'b0;
      build_stimulus();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (!(all_sent && !req_valid && token_queue.size() == 0) &&
             cycle_count < CYCLE_STOP)
         @(posedge clock);
      if (cycle_count >= CYCLE_STOP) begin
         $display("[s_expression_lexer_top] ERROR");
      end else begin
         repeat (20) @(posedge clock);   // catch any stray tokens
         if (error_count == 0 && token_queue.size() == 0)
            $display("[s_expression_lexer_top] OK");
         else
            $display("[s_expression_lexer_top] ERROR");
      end
      $finish;
   end

endmodule
